FILE: src/rdpd_pkg.sv
// Package: word types, register map and constants of the rotary dial pulse decoder.
package rdpd_pkg;

  // Input word: one sample tick of both contacts plus the digit-take flag
  typedef struct packed {
    logic rotor_level;
    logic pulse_level;
    logic take_digit;
  } in_word_t;

  // Result word: held digit and its ready flag
  typedef struct packed {
    logic [3:0] digit_value;
    logic       digit_ready;
  } out_word_t;

  localparam int unsigned HOLDOFF_W = 16;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned DATA_W    = 32;

  // Register select is address bit 2 (registers at byte addresses 0 and 4)
  localparam logic REG_ROTOR_HOLDOFF = 1'b0;
  localparam logic REG_PULSE_HOLDOFF = 1'b1;

  localparam logic [HOLDOFF_W-1:0] ROTOR_HOLDOFF_RST = 16'd1000;
  localparam logic [HOLDOFF_W-1:0] PULSE_HOLDOFF_RST = 16'd100;

  // Pulse count wraps from the last digit back to zero (ten pulses give 0)
  localparam logic [DIGIT_W-1:0] DIGIT_LAST = 4'd9;

endpackage

FILE: src/rotary_dial_pulse_decoder.sv
// Top level: rotary dial pulse decoder with holdoff filtering and APB register port.
//
// Each input word is one sample tick of the rotor (off-normal) contact, the pulse
// contact and a take-digit flag; every word yields exactly one result word carrying
// the held digit and its ready flag after that tick's update. A word is captured in
// an input register, processed by counter/flag logic that updates the decoder
// state, and its result is placed in an output register, so the block takes one
// word per cycle while the output is not stalled; a stalled output holds at most
// one word in each of the two registers. Holdoff values are written over the APB
// port at byte address 0 (rotor) and 4 (pulse); the user must write them only while
// no word is in flight, as the block itself does not enforce this. A new value applies
// to the next accepted contact edge, not to a holdoff already counting down.
module rotary_dial_pulse_decoder (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  rdpd_pkg::in_word_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output rdpd_pkg::out_word_t                out_data,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rdpd_pkg::ADDR_W-1:0]        paddr,
  input  logic [rdpd_pkg::DATA_W-1:0]        pwdata,
  output logic [rdpd_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);
  import rdpd_pkg::*;

  // Configuration registers
  logic [HOLDOFF_W-1:0] rotor_holdoff_r;
  logic [HOLDOFF_W-1:0] pulse_holdoff_r;

  // Pipeline registers
  logic      s1_valid_r;
  in_word_t  s1_word_r;
  logic      out_valid_r;
  out_word_t out_word_r;

  // Decoder state
  logic                 rotor_active_r, rotor_active_nxt;
  logic                 pulse_high_r, pulse_high_nxt;
  logic [HOLDOFF_W-1:0] rotor_wait_r, rotor_wait_nxt;
  logic [HOLDOFF_W-1:0] pulse_wait_r, pulse_wait_nxt;
  logic [DIGIT_W-1:0]   pulse_count_r, pulse_count_nxt;
  logic [DIGIT_W-1:0]   held_digit_r, held_digit_nxt;
  logic                 ready_flag_r, ready_flag_nxt;

  logic s1_adv;
  logic cfg_wr;

  // Advance the processing stage when the output register is free or drains
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  // APB register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      REG_ROTOR_HOLDOFF: prdata = {{(DATA_W-HOLDOFF_W){1'b0}}, rotor_holdoff_r};
      REG_PULSE_HOLDOFF: prdata = {{(DATA_W-HOLDOFF_W){1'b0}}, pulse_holdoff_r};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rotor_holdoff_r <= ROTOR_HOLDOFF_RST;
      pulse_holdoff_r <= PULSE_HOLDOFF_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_ROTOR_HOLDOFF: rotor_holdoff_r <= pwdata[HOLDOFF_W-1:0];
        REG_PULSE_HOLDOFF: pulse_holdoff_r <= pwdata[HOLDOFF_W-1:0];
        default: ;
      endcase
    end
  end

  // One tick of the decoder: take, rotor contact, then pulse contact
  always_comb begin
    rotor_active_nxt = rotor_active_r;
    pulse_high_nxt   = pulse_high_r;
    rotor_wait_nxt   = rotor_wait_r;
    pulse_wait_nxt   = pulse_wait_r;
    pulse_count_nxt  = pulse_count_r;
    held_digit_nxt   = held_digit_r;
    ready_flag_nxt   = ready_flag_r;

    // Drop ready before the update when the digit is taken
    if (s1_word_r.take_digit) begin
      ready_flag_nxt = 1'b0;
    end

    // Rotor contact: count down holdoff, else accept a level change
    if (rotor_wait_r != '0) begin
      rotor_wait_nxt = rotor_wait_r - 16'd1;
    end else if (s1_word_r.rotor_level != rotor_active_r) begin
      rotor_active_nxt = s1_word_r.rotor_level;
      rotor_wait_nxt   = rotor_holdoff_r;
      if (!s1_word_r.rotor_level) begin
        held_digit_nxt  = pulse_count_r;
        ready_flag_nxt  = 1'b1;
        pulse_count_nxt = '0;
      end
    end

    // Pulse contact: tracked only while the rotor is off normal
    if (rotor_active_nxt) begin
      if (pulse_wait_r != '0) begin
        pulse_wait_nxt = pulse_wait_r - 16'd1;
      end else if (s1_word_r.pulse_level != pulse_high_r) begin
        pulse_high_nxt = s1_word_r.pulse_level;
        pulse_wait_nxt = pulse_holdoff_r;
        if (s1_word_r.pulse_level) begin
          pulse_count_nxt = (pulse_count_nxt == DIGIT_LAST) ? '0
                                                            : pulse_count_nxt + 4'd1;
        end
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_word_r <= in_data;
    end
  end

  // Decoder state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rotor_active_r <= 1'b0;
      pulse_high_r   <= 1'b0;
      rotor_wait_r   <= '0;
      pulse_wait_r   <= '0;
      pulse_count_r  <= '0;
      held_digit_r   <= '0;
      ready_flag_r   <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (s1_adv) begin
        rotor_active_r <= rotor_active_nxt;
        pulse_high_r   <= pulse_high_nxt;
        rotor_wait_r   <= rotor_wait_nxt;
        pulse_wait_r   <= pulse_wait_nxt;
        pulse_count_r  <= pulse_count_nxt;
        held_digit_r   <= held_digit_nxt;
        ready_flag_r   <= ready_flag_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_ready) begin
        out_valid_r    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_word_r.digit_value <= held_digit_nxt;
      out_word_r.digit_ready <= ready_flag_nxt;
    end
  end

  // Pulse count never leaves the digit range
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    pulse_count_r <= DIGIT_LAST)
    else $error("pulse count out of digit range");

  // A presented digit is always a decimal digit
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_word_r.digit_value <= DIGIT_LAST)
    else $error("output digit out of range");

  // Rotor state cannot change while its holdoff is counting
  a_rotor_holdoff: assert property (@(posedge clk) disable iff (!rst_n)
    rotor_wait_r != '0 |=> $stable(rotor_active_r))
    else $error("rotor edge accepted during holdoff");

  // Pulse count only moves while the rotor is off normal or on its return edge
  a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !rotor_active_r && !rotor_active_nxt && s1_adv |=> pulse_count_r == $past(pulse_count_r))
    else $error("pulse counted with rotor at rest");

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the rotary dial pulse decoder: dialed digits, noise, holdoff settings.
module testbench;
  import rdpd_pkg::*;

  // Track decoder state per accepted tick and hold the result words still due
  class dial_scoreboard;
    logic [HOLDOFF_W-1:0] rotor_holdoff;
    logic [HOLDOFF_W-1:0] pulse_holdoff;
    logic [HOLDOFF_W-1:0] rotor_wait;
    logic [HOLDOFF_W-1:0] pulse_wait;
    bit                   rotor_on;
    bit                   pulse_closed;
    bit                   ready;
    logic [DIGIT_W-1:0]   count;
    logic [DIGIT_W-1:0]   digit;
    out_word_t            digits_due[$];
    int                   mismatches;
    int                   words_checked;

    function new();
      rotor_holdoff = ROTOR_HOLDOFF_RST;
      pulse_holdoff = PULSE_HOLDOFF_RST;
      rotor_wait    = '0;
      pulse_wait    = '0;
      rotor_on      = 1'b0;
      pulse_closed  = 1'b0;
      ready         = 1'b0;
      count         = '0;
      digit         = '0;
      mismatches    = 0;
      words_checked = 0;
    endfunction

    function void set_holdoff(logic sel, logic [HOLDOFF_W-1:0] value);
      if (sel == REG_ROTOR_HOLDOFF) begin
        rotor_holdoff = value;
      end else begin
        pulse_holdoff = value;
      end
    endfunction

    // Advance one sample tick and queue the word it must produce
    function void note_tick(in_word_t w);
      out_word_t want;
      if (w.take_digit) begin
        ready = 1'b0;
      end
      // rotor contact: count down the holdoff or take a new edge
      if (rotor_wait != 0) begin
        rotor_wait = rotor_wait - 1'b1;
      end else if (w.rotor_level != rotor_on) begin
        rotor_on   = w.rotor_level;
        rotor_wait = rotor_holdoff;
        if (!w.rotor_level) begin
          digit = count;
          ready = 1'b1;
          count = '0;
        end
      end
      // pulse contact: only watched while the dial is off normal
      if (rotor_on) begin
        if (pulse_wait != 0) begin
          pulse_wait = pulse_wait - 1'b1;
        end else if (w.pulse_level != pulse_closed) begin
          pulse_closed = w.pulse_level;
          pulse_wait   = pulse_holdoff;
          if (w.pulse_level) begin
            count = (count == DIGIT_LAST) ? '0 : count + 1'b1;
          end
        end
      end
      want.digit_value = digit;
      want.digit_ready = ready;
      digits_due.push_back(want);
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (digits_due.size() == 0) begin
        $display("%0t: unexpected word digit_value=%0d digit_ready=%0b",
                 $time, got.digit_value, got.digit_ready);
        mismatches++;
      end else begin
        want = digits_due.pop_front();
        words_checked++;
        if (got.digit_value !== want.digit_value) begin
          $display("%0t: digit_value expected %0d, got %0d",
                   $time, want.digit_value, got.digit_value);
          mismatches++;
        end
        if (got.digit_ready !== want.digit_ready) begin
          $display("%0t: digit_ready expected %0b, got %0b",
                   $time, want.digit_ready, got.digit_ready);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return digits_due.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_word_t            in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_word_t           out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  dial_scoreboard sb = new();
  int             words_sent = 0;
  bit             calm = 1'b0;

  rotary_dial_pulse_decoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  // Watch both channels: predict on each accepted tick, check each delivered word
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_tick(in_data);
      end
      if (out_valid && out_ready) begin
        sb.check_word(out_data);
      end
    end
  end

  // Offer one tick word, with an occasional gap ahead of it
  task automatic send_word(input bit rotor, input bit pulse, input bit take);
    in_word_t w;
    w.rotor_level = rotor;
    w.pulse_level = pulse;
    w.take_digit  = take;
    if (!calm && ((words_sent >> 6) % 3 != 2) && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  // Hold off input until every due word has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input logic sel, input logic [HOLDOFF_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= {{(DATA_W-HOLDOFF_W){1'b0}}, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_holdoff(sel, value);
    @(posedge clk);
  endtask

  // Dial one digit: rotor off normal, pulses past the holdoff (optionally bouncing inside it), rotor back
  task automatic dial_digit(input int pulses, input bit noisy);
    int  up_ticks;
    int  span;
    int  k;
    int  t;
    bit  level;
    send_word(1'b1, 1'b0, $urandom_range(0, 3) == 0);
    up_ticks = 1;
    for (k = 0; k < 2 * pulses; k++) begin
      span = sb.pulse_holdoff + 1 + $urandom_range(0, 2);
      for (t = 0; t < span; t++) begin
        level = (k % 2 == 0);
        // bounce only inside the holdoff window, where it must be ignored
        if (noisy && t >= 1 && t <= sb.pulse_holdoff) begin
          level = 1'($urandom_range(0, 1));
        end
        send_word(1'b1, level, $urandom_range(0, 3) == 0);
        up_ticks++;
      end
    end
    while (up_ticks <= sb.rotor_holdoff) begin
      send_word(1'b1, 1'b0, $urandom_range(0, 3) == 0);
      up_ticks++;
    end
    span = sb.rotor_holdoff + 1 + $urandom_range(0, 2);
    for (t = 0; t < span; t++) begin
      level = 1'b0;
      if (noisy && t >= 1 && t <= sb.rotor_holdoff) begin
        level = 1'($urandom_range(0, 1));
      end
      send_word(level, noisy ? 1'($urandom_range(0, 1)) : 1'b0,
                $urandom_range(0, 3) == 0);
    end
  endtask

  // Set both holdoffs, then dial (or send raw noise) until the word count is reached
  task automatic dial_phase(input logic [HOLDOFF_W-1:0] rotor_ticks,
                            input logic [HOLDOFF_W-1:0] pulse_ticks,
                            input int stop_at, input bit noise_only);
    drain();
    reg_write(REG_ROTOR_HOLDOFF, rotor_ticks);
    reg_write(REG_PULSE_HOLDOFF, pulse_ticks);
    while (words_sent < stop_at) begin
      if (noise_only || $urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        end
      end else begin
        dial_digit($urandom_range(1, 12), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Drain result words; stall in short bursts and once for a long stretch
  initial begin : result_sink
    int rx_cycles;
    bit long_hold_done;
    rx_cycles      = 0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk);
      rx_cycles++;
      if (!long_hold_done && sb.words_checked >= 120) begin
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (60) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!calm && ((rx_cycles >> 6) % 3 != 1) && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int i;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset holdoffs: rotor at rest, pulse and take have no effect on the digit
    send_word(1'b0, 1'b1, 1'b1);

    // zero holdoff: ten pulses wrap to digit 0
    drain();
    reg_write(REG_ROTOR_HOLDOFF, 16'd0);
    reg_write(REG_PULSE_HOLDOFF, 16'd0);
    send_word(1'b1, 1'b1, 1'b0);
    for (i = 0; i < 9; i++) begin
      send_word(1'b1, 1'b0, 1'b0);
      send_word(1'b1, 1'b1, 1'b0);
    end
    // rotor returns while the digit is taken in the same tick
    send_word(1'b0, 1'b1, 1'b1);
    // pulse contact moves with the rotor at rest: ignored
    send_word(1'b0, 1'b0, 1'b0);
    send_word(1'b1, 1'b0, 1'b0);
    send_word(1'b1, 1'b1, 1'b0);
    // new digit replaces the unread one
    send_word(1'b0, 1'b1, 1'b0);
    send_word(1'b0, 1'b0, 1'b1);

    dial_phase(16'd1, 16'd2, 275, 1'b0);
    dial_phase(16'd3, 16'd0, 475, 1'b0);
    dial_phase(16'd0, 16'd3, 675, 1'b0);
    dial_phase(16'd2, 16'd1, 825, 1'b0);
    calm = 1'b1;
    dial_phase(16'd5, 16'd4, 900, 1'b0);
    dial_phase(16'd0, 16'hFFFF, 925, 1'b1);
    dial_phase(16'hFFFF, 16'hFFFF, 950, 1'b1);

    drain();
    repeat (6) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
